FILE: design/ngfe_pkg.sv
// Shared types and constants for the NMEA GGA/GLL field extractor.
// No dependencies.
package ngfe_pkg;

  // default field capacity in bytes, range 1 to 15
  localparam int FIELD_MAX_DEF = 15;
  localparam int SLOTS         = 4;
  localparam int LEN_W         = 4;

  // ascii codes that steer the parser
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_L      = 8'h4C;

  // comma counts of a complete sentence
  localparam logic [3:0] GGA_COMMAS = 4'd14;
  localparam logic [3:0] GLL_COMMAS = 4'd7;
  localparam logic [3:0] COMMA_SAT  = 4'd15;
  localparam logic [2:0] POS_SAT    = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_DAMAGED = 2'd2;

  // emission sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_RDATA,
    ST_END,
    ST_DMG
  } state_e;

endpackage

FILE: design/ngfe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on ngfe_pkg for default sizes.
module ngfe_ram import ngfe_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = SLOTS * FIELD_MAX_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/nmea_gga_gll_field_extractor.sv
// An ordinary byte is taken while input is not stalled and gives no result.
// A '$' closing a bad sentence enters the damaged state, which loads the
// damaged result once the output is free. A '$' closing a good sentence
// starts a burst paced by the store's single read port with registered read
// data (one read and one output load per byte); input stalls during the burst.
// Reset clears all control state; the field store is left unwritten, no clear.
module nmea_gga_gll_field_extractor import ngfe_pkg::*; #(
  parameter int FIELD_MAX = FIELD_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] field_slot_o,
  output logic       truncated_o,
  output logic       last_o
);

  localparam int DEPTH = SLOTS * FIELD_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LEN_W-1:0] FMAX = LEN_W'(FIELD_MAX);

  // slot of the open field: {captured, slot}
  function automatic logic [2:0] slot_of(input logic [3:0] cc, input logic gga);
    logic [2:0] r;
    r = 3'b000;
    priority if (cc >= 4'd1 && cc <= 4'd4) r = {1'b1, 2'(cc - 4'd1)};
    else if (gga && cc == 4'd5) r = 3'b100;
    else if (gga && cc == 4'd6) r = 3'b101;
    else if (gga && cc == 4'd7) r = 3'b110;
    else if (gga && cc == 4'd9) r = 3'b111;
    else r = 3'b000;
    return r;
  endfunction

  state_e state_q, state_d;

  logic             in_sent_q, in_sent_d;
  logic [2:0]       pos_q, pos_d;
  logic [7:0]       type_q [3];
  logic [7:0]       type_d [3];
  logic [7:0]       type_upd [3];
  logic [3:0]       comma_q, comma_d, comma_upd;
  logic [LEN_W-1:0] len_q [SLOTS];
  logic [LEN_W-1:0] len_d [SLOTS];
  logic             ovf_q [SLOTS];
  logic             ovf_d [SLOTS];
  logic [1:0]       s_q, s_d;
  logic [LEN_W-1:0] i_q, i_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       kind_q;
  logic [7:0]       byte_q;
  logic [1:0]       slot_q;
  logic             trunc_q, last_q;

  logic             in_acc, is_dollar, is_comma, ok, out_free;
  logic [2:0]       sel;
  logic             rd_en, load_byte, load_end, load_dmg;
  logic             mem_we;
  logic [AW-1:0]    waddr, raddr;
  logic [7:0]       rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_dollar  = (in_byte_i == CH_DOLLAR);
  assign is_comma   = (in_byte_i == CH_COMMA);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign ok = ((type_q[0] == CH_G) && (type_q[1] == CH_G) && (type_q[2] == CH_A) &&
               (comma_q == GGA_COMMAS)) ||
              ((type_q[0] == CH_G) && (type_q[1] == CH_L) && (type_q[2] == CH_L) &&
               (comma_q == GLL_COMMAS));

  // type letters and comma count as updated by the current byte
  always_comb begin
    type_upd = type_q;
    if (pos_q >= 3'd2 && pos_q <= 3'd4) begin
      type_upd[2'(pos_q - 3'd2)] = in_byte_i;
    end
    comma_upd = comma_q;
    if (is_comma && comma_q < COMMA_SAT) begin
      comma_upd = comma_q + 4'd1;
    end
  end

  assign sel = slot_of(comma_upd, (type_upd[0] == CH_G) && (type_upd[1] == CH_G) &&
                                  (type_upd[2] == CH_A));

  // store write for a captured field byte
  assign mem_we = in_acc && in_sent_q && !is_dollar && !is_comma && sel[2] &&
                  (len_q[sel[1:0]] < FMAX);
  assign waddr  = AW'(32'(sel[1:0]) * FIELD_MAX + 32'(len_q[sel[1:0]]));
  assign raddr  = AW'(32'(s_q) * FIELD_MAX + 32'(i_q));

  ngfe_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(waddr),
    .wdata_i(in_byte_i),
    .re_i   (rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_dollar && in_sent_q) begin
          state_d = ok ? ST_SLOT : ST_DMG;
        end
      end
      ST_SLOT:  state_d = (i_q < len_q[s_q]) ? ST_RDATA : ST_END;
      ST_RDATA: if (out_free) state_d = ST_SLOT;
      ST_END: begin
        if (out_free) state_d = (s_q == 2'(SLOTS - 1)) ? ST_IDLE : ST_SLOT;
      end
      ST_DMG:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    rd_en     = 1'b0;
    load_byte = 1'b0;
    load_end  = 1'b0;
    load_dmg  = 1'b0;
    unique case (state_q)
      ST_IDLE:  ;
      ST_SLOT:  rd_en = (i_q < len_q[s_q]);
      ST_RDATA: load_byte = out_free;
      ST_END:   load_end = out_free;
      ST_DMG:   load_dmg = out_free;
      default:  ;
    endcase
  end

  // sentence state update
  always_comb begin
    in_sent_d = in_sent_q;
    pos_d     = pos_q;
    type_d    = type_q;
    comma_d   = comma_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    if (in_acc) begin
      if (is_dollar) begin
        in_sent_d = 1'b1;
        pos_d     = '0;
        type_d    = '{default: 8'h00};
        comma_d   = '0;
        if (!(in_sent_q && ok)) begin
          len_d = '{default: '0};
          ovf_d = '{default: 1'b0};
        end
      end else if (in_sent_q) begin
        type_d  = type_upd;
        comma_d = comma_upd;
        if (pos_q < POS_SAT) pos_d = pos_q + 3'd1;
        if (sel[2]) begin
          if (is_comma) begin
            len_d[sel[1:0]] = '0;
            ovf_d[sel[1:0]] = 1'b0;
          end else if (len_q[sel[1:0]] < FMAX) begin
            len_d[sel[1:0]] = len_q[sel[1:0]] + LEN_W'(1);
          end else begin
            ovf_d[sel[1:0]] = 1'b1;
          end
        end
      end
    end
    // a slot is released once its end marker has gone out
    if (load_end) begin
      len_d[s_q] = '0;
      ovf_d[s_q] = 1'b0;
    end
  end

  // burst counters
  always_comb begin
    s_d = s_q;
    i_d = i_q;
    if (state_q == ST_IDLE && state_d == ST_SLOT) begin
      s_d = '0;
      i_d = '0;
    end else if (load_byte) begin
      i_d = i_q + LEN_W'(1);
    end else if (load_end) begin
      s_d = s_q + 2'd1;
      i_d = '0;
    end
  end

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_byte || load_end || load_dmg) out_valid_d = 1'b1;
    else if (!out_stall_i)                 out_valid_d = 1'b0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_sent_q   <= 1'b0;
      pos_q       <= '0;
      type_q      <= '{default: 8'h00};
      comma_q     <= '0;
      len_q       <= '{default: '0};
      ovf_q       <= '{default: 1'b0};
      s_q         <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_sent_q   <= in_sent_d;
      pos_q       <= pos_d;
      type_q      <= type_d;
      comma_q     <= comma_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      s_q         <= s_d;
      i_q         <= i_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (load_byte) begin
      kind_q  <= KIND_BYTE;
      byte_q  <= rdata;
      slot_q  <= s_q;
      trunc_q <= 1'b0;
      last_q  <= 1'b0;
    end else if (load_end) begin
      kind_q  <= KIND_END;
      byte_q  <= 8'h00;
      slot_q  <= s_q;
      trunc_q <= ovf_q[s_q];
      last_q  <= (s_q == 2'(SLOTS - 1));
    end else if (load_dmg) begin
      kind_q  <= KIND_DAMAGED;
      byte_q  <= 8'h00;
      slot_q  <= 2'd0;
      trunc_q <= 1'b0;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign out_byte_o   = byte_q;
  assign field_slot_o = slot_q;
  assign truncated_o  = trunc_q;
  assign last_o       = last_q;

  // store is written only while no burst reads it
  a_no_write_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE))
    else $error("field store written during emission");

  // field lengths never pass capacity
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q[0] <= FMAX) && (len_q[1] <= FMAX) && (len_q[2] <= FMAX) && (len_q[3] <= FMAX))
    else $error("field length above capacity");

  // a damaged result always closes the burst
  a_dmg_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_DAMAGED) |-> last_o)
    else $error("damaged result without last");

  // last end marker belongs to the final slot
  a_end_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_END && last_o) |-> (field_slot_o == 2'(SLOTS - 1)))
    else $error("last marker on wrong slot");

  // a burst ends in idle with slots 0 and 3 released
  a_burst_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_end && s_q == 2'(SLOTS - 1)) |=>
      (state_q == ST_IDLE) && (len_q[0] == '0) && (len_q[3] == '0))
    else $error("slots not released after burst");

endmodule

FILE: bench/tb.sv
// Self-checking bench for the NMEA GGA/GLL field extractor: a byte stream in,
// field beats out, with a built-in predictor of the expected beats.
// Depends on ngfe_pkg and nmea_gga_gll_field_extractor.
module tb;
  import ngfe_pkg::*;

  localparam int FMAX = FIELD_MAX_DEF;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] slot;
    logic       trunc;
    logic       last;
  } field_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic [1:0] field_slot_o;
  logic       truncated_o;
  logic       last_o;

  // no idling on either side while set
  bit calm;

  // parser state as the predictor sees it
  bit         p_open;
  logic [2:0] p_pos;
  logic [7:0] p_type [3];
  logic [3:0] p_commas;
  logic [7:0] p_store [SLOTS*FMAX];
  logic [3:0] p_len [SLOTS];
  logic       p_ovf [SLOTS];

  field_beat_t expected_beats_q[$];

  int n_errors, n_bytes, n_beats, n_good, n_damaged;

  nmea_gga_gll_field_extractor #(
    .FIELD_MAX(FMAX)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .field_slot_o(field_slot_o),
    .truncated_o (truncated_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  // one line per mismatch, printing capped so a broken block cannot flood the log
  task automatic report(input string msg);
    if (n_errors < 100) $display("mismatch: %s", msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic bit type_is(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c);
    return p_type[0] == a && p_type[1] == b && p_type[2] == c;
  endfunction

  // slot of the field now open, -1 when it is not kept
  function automatic int open_slot();
    if (p_commas >= 1 && p_commas <= 4) return int'(p_commas) - 1;
    // gga keeps fields 5, 6, 7 and 9
    if (type_is(CH_G, CH_G, CH_A)) begin
      case (p_commas)
        4'd5: return 0;
        4'd6: return 1;
        4'd7: return 2;
        4'd9: return 3;
        default: return -1;
      endcase
    end
    return -1;
  endfunction

  function automatic void start_sentence();
    p_pos    = '0;
    p_commas = '0;
    for (int i = 0; i < 3; i++) p_type[i] = '0;
    for (int s = 0; s < SLOTS; s++) begin
      p_len[s] = '0;
      p_ovf[s] = 1'b0;
    end
  endfunction

  // burst of beats expected when an open sentence is closed by '$'
  task automatic expect_sentence_close();
    field_beat_t b;
    if ((type_is(CH_G, CH_G, CH_A) && p_commas == GGA_COMMAS) ||
        (type_is(CH_G, CH_L, CH_L) && p_commas == GLL_COMMAS)) begin
      n_good++;
      for (int s = 0; s < SLOTS; s++) begin
        for (int i = 0; i < p_len[s]; i++) begin
          b = '{KIND_BYTE, p_store[s*FMAX+i], 2'(s), 1'b0, 1'b0};
          expected_beats_q.push_back(b);
        end
        b = '{KIND_END, 8'd0, 2'(s), p_ovf[s], (s == SLOTS - 1)};
        expected_beats_q.push_back(b);
      end
    end else begin
      n_damaged++;
      b = '{KIND_DAMAGED, 8'd0, 2'd0, 1'b0, 1'b1};
      expected_beats_q.push_back(b);
    end
  endtask

  task automatic predict_byte(input logic [7:0] c);
    int s;
    if (c == CH_DOLLAR) begin
      if (p_open) expect_sentence_close();
      p_open = 1'b1;
      start_sentence();
    end else if (p_open) begin
      // type letters sit at positions 2..4 after the '$', commas included
      if (p_pos >= 2 && p_pos <= 4) p_type[p_pos-2] = c;
      if (p_pos < POS_SAT) p_pos++;
      if (c == CH_COMMA) begin
        if (p_commas < COMMA_SAT) p_commas++;
        s = open_slot();
        if (s >= 0) begin
          p_len[s] = '0;
          p_ovf[s] = 1'b0;
        end
      end else begin
        s = open_slot();
        if (s >= 0) begin
          if (p_len[s] < FMAX) begin
            p_store[s*FMAX+p_len[s]] = c;
            p_len[s]++;
          end else begin
            p_ovf[s] = 1'b1;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- driving

  // one input beat: random hold-off, then valid until accepted
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_byte_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(c);
    n_bytes++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
  endtask

  // any byte that is plain field text
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_DOLLAR || b == CH_COMMA);
    return b;
  endfunction

  // mostly short fields, now and then a long one that may pass what the store keeps
  task automatic send_field();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 19) : $urandom_range(0, 4);
    repeat (len) send_byte(text_byte());
  endtask

  // well-formed sentences most of the time, wrong comma counts and noise otherwise
  task automatic send_random_sentence();
    int form, ncommas, nhdr;
    logic [7:0] t [3];
    form    = $urandom_range(0, 7);
    calm    = ($urandom_range(0, 3) == 0);
    nhdr    = 3;
    ncommas = $urandom_range(0, 18);
    if (form <= 2) begin
      t = '{CH_G, CH_G, CH_A};
      ncommas = GGA_COMMAS;
    end else if (form <= 5) begin
      t = '{CH_G, CH_L, CH_L};
      ncommas = GLL_COMMAS;
    end else if (form == 6) begin
      if ($urandom_range(0, 1)) begin
        t = '{CH_G, CH_G, CH_A};
        if (ncommas == GGA_COMMAS) ncommas++;
      end else begin
        t = '{CH_G, CH_L, CH_L};
        if (ncommas == GLL_COMMAS) ncommas++;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 4))
          0: t[i] = CH_G;
          1: t[i] = CH_L;
          2: t[i] = CH_A;
          3: t[i] = CH_COMMA;
          default: t[i] = text_byte();
        endcase
      end
      if ($urandom_range(0, 2) == 0) begin
        nhdr    = $urandom_range(0, 2);
        ncommas = 0;
      end
    end
    send_byte(CH_DOLLAR);
    send_byte($urandom_range(0, 1) ? CH_G : text_byte());
    send_byte(text_byte());
    for (int i = 0; i < nhdr; i++) send_byte(t[i]);
    repeat (ncommas) begin
      send_byte(CH_COMMA);
      send_field();
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_beat();
    field_beat_t want;
    n_beats++;
    if (expected_beats_q.size() == 0) begin
      report($sformatf("unexpected beat kind %0d byte %02h slot %0d",
                       kind_o, out_byte_o, field_slot_o));
    end else begin
      want = expected_beats_q.pop_front();
      if (kind_o !== want.kind)
        report($sformatf("beat %0d kind %0d, want %0d", n_beats, kind_o, want.kind));
      if (out_byte_o !== want.data)
        report($sformatf("beat %0d byte %02h, want %02h", n_beats, out_byte_o, want.data));
      if (field_slot_o !== want.slot)
        report($sformatf("beat %0d slot %0d, want %0d", n_beats, field_slot_o, want.slot));
      if (truncated_o !== want.trunc)
        report($sformatf("beat %0d truncated %0d, want %0d", n_beats, truncated_o,
                         want.trunc));
      if (last_o !== want.last)
        report($sformatf("beat %0d last %0d, want %0d", n_beats, last_o, want.last));
    end
  endtask

  // result side: random stall per beat, then take it
  initial begin
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 7);
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      check_beat();
    end
  end

  // ---------------------------------------------------------------- tests

  // text before the first '$' is dropped, and that '$' gives nothing
  task automatic test_noise_before_sync();
    send_text("x1,AB,*");
    send_byte(8'hFF);
    send_byte(CH_DOLLAR);
  endtask

  // complete gga (refilled early slots, checksum text) and complete gll
  task automatic test_good_sentences();
    send_text("GPGGA,1235,48.0,N,011.0,E,1,08,0.9,54,M,46,M,,*47\r\n");
    send_text("$GPGLL,49.4,N,123.1,W,2254,A,*1D\r\n");
  endtask

  // empty fields, two fields over capacity and one exactly at capacity
  task automatic test_empty_and_long_fields();
    send_text("$GPGLL,,,,,,,");
    send_text("$GPGLL,ABCDEFGHIJKLMNOPQRST,0123456789abcde,0123456789abcdef,x,,,");
  endtask

  // byte extremes and control characters as field text
  task automatic test_byte_extremes();
    send_text("$GPGLL,");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_COMMA);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_text(",\r\n,*,,,");
  endtask

  // wrong comma count, short header, comma as a type letter, comma overflow,
  // and an empty sentence
  task automatic test_damaged_sentences();
    send_text("$GPGGA");
    repeat (13) send_byte(CH_COMMA);
    send_text("$GP");
    send_text("$G,,,,,,,");
    send_text("$GPGLL");
    repeat (20) send_byte(CH_COMMA);
    send_byte(CH_DOLLAR);
  endtask

  // random sentences until the whole run has sent about 280 bytes
  task automatic test_random_stream();
    do send_random_sentence(); while (n_bytes < 280);
    calm = 1'b0;
    // a closing '$' flushes the last sentence
    send_byte(CH_DOLLAR);
  endtask

  initial begin
    int guard;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i  = 8'd0;
    calm       = 1'b0;
    p_open     = 1'b0;
    start_sentence();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_noise_before_sync();
    test_good_sentences();
    test_empty_and_long_fields();
    test_byte_extremes();
    test_damaged_sentences();
    test_random_stream();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    guard = 0;
    while (expected_beats_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (expected_beats_q.size() != 0)
      report($sformatf("%0d beats never arrived", expected_beats_q.size()));

    $display("run covered %0d input bytes: %0d complete and %0d damaged sentences,",
             n_bytes, n_good, n_damaged);
    $display("%0d result beats checked, %0d mismatches", n_beats, n_errors);
    if (n_errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #400000;
    $display("tb failed");
    $finish;
  end

endmodule
